// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the colour converter.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, prop)
`define ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// File: hw/rtl/s2lab_pkg.sv
// Package of the sRGB to CIELAB converter: widths, matrix and linearisation table.
// Self-contained; used by s2lab_froot and srgb_to_cielab.
package s2lab_pkg;

  localparam int LIN_W = 25;
  localparam int N_W   = 25;
  localparam int F_W   = 21;

  typedef logic [LIN_W-1:0] lin_t;
  typedef lin_t lin_tab_t [256];

  // Matrix rows in Q20 with the white point already divided out.
  localparam logic [19:0] MAT_Q20 [9] = '{
    20'd455029, 20'd394485, 20'd199062,
    20'd223004, 20'd749891, 20'd75681,
    20'd18619,  20'd114786, 20'd915171
  };

  // n above this lies above the cube-root knee.
  localparam longint KNEE_N  = (64'd216 << 24) / 24389;
  // Offset and reciprocal of the linear segment below the knee.
  localparam longint LIN_OFS = 64'd7247757312 + 64'd25056;
  localparam longint DIV_K   = (64'd1 << 38) / 783;

  function automatic logic [63:0] pow5_q30(input logic [63:0] r);
    logic [63:0] p;
    p = r;
    for (int i = 0; i < 4; i++) begin
      p = (p * r) >> 30;
    end
    return p;
  endfunction

  function automatic lin_t lin_q24(input int v);
    logic [63:0] vv, t, t2, lo, hi, mid, res;
    vv = 64'(v);
    lo = '0;
    hi = 64'd1 << 30;
    if (v <= 10) begin
      res = (vv * 64'd100 * (64'd1 << 24) + 64'd164730) / 64'd329460;
    end else begin
      t  = (((64'd1000 * vv + 64'd14025) << 30) + 64'd134512) / 64'd269025;
      t2 = (t * t + (64'd1 << 29)) >> 30;
      for (int i = 0; i < 32; i++) begin
        if (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          if (pow5_q30(mid) <= t2) lo = mid;
          else hi = mid - 64'd1;
        end
      end
      res = (t2 * lo + (64'd1 << 35)) >> 36;
    end
    return res[LIN_W-1:0];
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t tab;
    for (int v = 0; v < 256; v++) begin
      tab[v] = lin_q24(v);
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();

endpackage

// File: hw/rtl/s2lab_froot.sv
// One lane of the CIELAB companding function f(n), pipelined over 22 stages.
// Depends on s2lab_pkg for widths and the knee constants.
module s2lab_froot import s2lab_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [N_W-1:0] n_in,
  output logic [F_W-1:0] f_out
);

  localparam int ROOT_BITS = 21;

  // Entry stage: knee test and numerator of the linear segment.
  logic [33:0] num;
  logic [27:0] m_val;
  logic [N_W-1:0] n0_r;
  logic knee0_r;
  logic [27:0] m0_r;

  assign num   = 34'(n_in[17:0]) * 34'd24389 + 34'(LIN_OFS);
  assign m_val = num[33:6];

  always_ff @(posedge clk) begin
    if (en) begin
      n0_r    <= n_in;
      knee0_r <= (64'(n_in) > 64'(KNEE_N));
      m0_r    <= m_val;
    end
  end

  // Linear segment: reciprocal product, estimate, one correction step, then a delay line.
  logic [56:0] mk1_r;
  logic [27:0] m1_r;
  logic [18:0] q2_r;
  logic [28:0] qm2_r;
  logic [27:0] m2_r;
  logic [18:0] q_est;
  logic [27:0] rem;
  logic [F_W-1:0] lq_line_r [ROOT_BITS-2];

  assign q_est = mk1_r[56:38];
  assign rem   = m2_r - qm2_r[27:0];

  always_ff @(posedge clk) begin
    if (en) begin
      mk1_r <= 57'(m0_r) * 57'(DIV_K);
      m1_r  <= m0_r;
      q2_r  <= q_est;
      qm2_r <= 29'(q_est) * 29'd783;
      m2_r  <= m1_r;
      lq_line_r[0] <= F_W'(q2_r) + ((rem >= 28'd783) ? F_W'(1) : F_W'(0));
      for (int i = 1; i < ROOT_BITS - 2; i++) begin
        lq_line_r[i] <= lq_line_r[i-1];
      end
    end
  end

  // Cube root, one result bit per stage, cube and square kept incrementally.
  logic [F_W-1:0] y_s   [ROOT_BITS+1];
  logic [63:0]    y2_s  [ROOT_BITS+1];
  logic [63:0]    y3_s  [ROOT_BITS+1];
  logic [N_W-1:0] n_s   [ROOT_BITS+1];
  logic           knee_s [ROOT_BITS+1];

  assign y_s[0]    = '0;
  assign y2_s[0]   = '0;
  assign y3_s[0]   = '0;
  assign n_s[0]    = n0_r;
  assign knee_s[0] = knee0_r;

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
    localparam int B = ROOT_BITS - 1 - k;
    logic [63:0] y64, big, c2, c3;
    logic take;
    logic [F_W-1:0] y_r;
    logic [63:0] y2_r, y3_r;
    logic [N_W-1:0] n_r;
    logic knee_r;

    always_comb begin
      y64  = 64'(y_s[k]);
      big  = 64'(n_s[k]) << 36;
      c3   = y3_s[k] + ((y2_s[k] + (y2_s[k] << 1)) << B)
           + ((y64 + (y64 << 1)) << (2 * B)) + (64'd1 << (3 * B));
      c2   = y2_s[k] + (y64 << (B + 1)) + (64'd1 << (2 * B));
      take = (c3 <= big);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        y_r    <= take ? (y_s[k] | (F_W'(1) << B)) : y_s[k];
        y2_r   <= take ? c2 : y2_s[k];
        y3_r   <= take ? c3 : y3_s[k];
        n_r    <= n_s[k];
        knee_r <= knee_s[k];
      end
    end

    assign y_s[k+1]    = y_r;
    assign y2_s[k+1]   = y2_r;
    assign y3_s[k+1]   = y3_r;
    assign n_s[k+1]    = n_r;
    assign knee_s[k+1] = knee_r;
  end

  assign f_out = knee_s[ROOT_BITS] ? y_s[ROOT_BITS] : lq_line_r[ROOT_BITS-3];

endmodule

// File: hw/rtl/srgb_to_cielab.sv
// sRGB (8 bits a channel) to CIELAB under D65; one item per cycle when not stalled.
// The datapath is fully pipelined: table read, matrix, then a
// 21-stage bit-per-stage cube root per channel, then the L, a, b output stage.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, active low) clears only the valid bits of the stages.
// Depends on s2lab_pkg, s2lab_froot and assert_macros.svh.
`include "assert_macros.svh"
module srgb_to_cielab import s2lab_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_lightness,
  output logic signed [15:0] out_a_star,
  output logic signed [15:0] out_b_star
);

  // Number of register stages from input to output.
  localparam int LAT   = 26;
  // Shift that takes a Q20 value to FRAC_BITS fraction bits.
  localparam int SH    = 20 - FRAC_BITS;
  localparam int L_MAX = ((100 << FRAC_BITS) > 32767) ? 32767 : (100 << FRAC_BITS);

  // One valid bit per stage; the pipeline moves as a whole.
  logic [LAT-1:0] vld_r;
  logic           en;

  assign en       = !(vld_r[LAT-1] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Stage 1: the sRGB curve is a constant table, read once per channel.
  lin_t lin_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      lin_r[0] <= LIN_TAB[in_red];
      lin_r[1] <= LIN_TAB[in_green];
      lin_r[2] <= LIN_TAB[in_blue];
    end
  end

  // Stage 2: the nine matrix products, 25 by 20 bits each.
  logic [44:0] prod_r [9];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[3*i+j] <= 45'(lin_r[j]) * 45'(MAT_Q20[3*i+j]);
        end
      end
    end
  end

  // Stage 3: row sums, rounded from Q44 back to Q24.
  logic [N_W-1:0] n_r [3];
  logic [46:0]    row_sum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      row_sum[i] = 47'(prod_r[3*i]) + 47'(prod_r[3*i+1]) + 47'(prod_r[3*i+2])
                 + (47'd1 << 19);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n_r[i] <= row_sum[i][20 +: N_W];
      end
    end
  end

  // Stages 4 to 25: f(n) for X, Y and Z in three identical lanes.
  logic [F_W-1:0] f_val [3];

  for (genvar c = 0; c < 3; c++) begin : g_lane
    s2lab_froot u_froot (
      .clk   (clk),
      .en    (en),
      .n_in  (n_r[c]),
      .f_out (f_val[c])
    );
  end

  // Stage 26: L = 116 fy - 16, a = 500 (fx - fy), b = 200 (fy - fz).
  // Rounding adds half and shifts arithmetically, so halves go upwards.
  logic signed [31:0] fx_s, fy_s, fz_s;
  logic signed [31:0] l_raw, a_raw, b_raw;

  always_comb begin
    fx_s  = signed'(32'(f_val[0]));
    fy_s  = signed'(32'(f_val[1]));
    fz_s  = signed'(32'(f_val[2]));
    l_raw = (32'sd116 * fy_s - 32'sd16777216 + (32'sd1 <<< (SH - 1))) >>> SH;
    a_raw = (32'sd500 * (fx_s - fy_s) + (32'sd1 <<< (SH - 1))) >>> SH;
    b_raw = (32'sd200 * (fy_s - fz_s) + (32'sd1 <<< (SH - 1))) >>> SH;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Black lies just below zero before rounding, hence the lower clamp.
      if (l_raw < 32'sd0) out_lightness <= '0;
      else if (l_raw > 32'(L_MAX)) out_lightness <= 15'(L_MAX);
      else out_lightness <= l_raw[14:0];

      if (a_raw > 32'sd32767) out_a_star <= 16'sh7fff;
      else if (a_raw < -32'sd32768) out_a_star <= 16'sh8000;
      else out_a_star <= a_raw[15:0];

      if (b_raw > 32'sd32767) out_b_star <= 16'sh7fff;
      else if (b_raw < -32'sd32768) out_b_star <= 16'sh8000;
      else out_b_star <= b_raw[15:0];
    end
  end

  // A frozen pipeline keeps every valid bit where it is.
  `ASSERT_NEXT(a_freeze_holds, !en, $stable(vld_r))
  // Lightness never leaves its clamped range.
  `ASSERT_ALWAYS(a_light_range, !out_valid || (32'(out_lightness) <= 32'(L_MAX)))
  // The input side is held only while a finished result waits.
  `ASSERT_ALWAYS(a_stall_cause, !in_stall || (out_valid && out_stall))

endmodule

// File: tb/srgb_to_cielab_test.sv
// Self-checking testbench of the sRGB to CIELAB converter (srgb_to_cielab).
// Depends on the RTL of the block and its package s2lab_pkg; predicts every result itself.
`timescale 1ns / 100ps
module srgb_to_cielab_test;

  localparam int FRAC = 8;
  localparam int MAX_WAIT = 17;
  localparam int N_RANDOM = 1070;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam longint L_TOP = ((64'd100 << FRAC) > 32767) ? 32767 : (64'd100 << FRAC);

  // One Lab result as the block presents it.
  typedef struct packed {
    logic [14:0] lightness;
    logic [15:0] a_star;
    logic [15:0] b_star;
  } lab_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_red;
  logic [7:0]  in_green;
  logic [7:0]  in_blue;
  logic        out_valid;
  logic        out_stall;
  logic [14:0] out_lightness;
  logic signed [15:0] out_a_star;
  logic signed [15:0] out_b_star;

  lab_t   lab_expected [$];
  longint linear_q24 [256];
  int     errors;
  int     items_sent;
  int     results_seen;
  int     cycles;
  bit     quiet_gaps;

  srgb_to_cielab i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_lightness (out_lightness),
    .out_a_star    (out_a_star),
    .out_b_star    (out_b_star)
  );

  // The clock runs from time zero with a 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Fifth power in Q30, each of the four products truncated.
  function automatic longint fifth_q30(input longint r);
    longint p;
    p = r;
    for (int i = 0; i < 4; i++) begin
      p = (p * r) >> 30;
    end
    return p;
  endfunction

  // Linearises one gamma-encoded code to Q24. Low codes use the straight segment;
  // the rest use t^2.4, found as t2 times the fifth root of t2.
  function automatic longint decode_gamma(input int code);
    longint t, t2, lo, hi, mid;
    if (code <= 10) begin
      return (longint'(code) * 100 * (64'd1 << 24) + 164730) / 329460;
    end
    t  = (((1000 * longint'(code) + 14025) << 30) + 134512) / 269025;
    t2 = (t * t + (64'd1 << 29)) >> 30;
    lo = 0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (fifth_q30(mid) <= t2) lo = mid;
      else hi = mid - 1;
    end
    return (t2 * lo + (64'd1 << 35)) >> 36;
  endfunction

  // The CIELAB companding curve in Q20: floor cube root above the knee,
  // the straight segment at or below it.
  function automatic longint lab_curve(input longint n);
    longint big, lo, hi, mid;
    if (n * 24389 > (64'd216 << 24)) begin
      big = n << 36;
      lo = 0;
      hi = 64'd1 << 20;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (mid * mid * mid <= big) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    end
    return (n * 24389 + 4 * 1728 * (64'd1 << 20) + 25056) / 50112;
  endfunction

  // Rounds a Q20 value to FRAC fraction bits, halves towards plus infinity.
  function automatic longint round_q20(input longint v);
    return (v + (64'sd1 << (19 - FRAC))) >>> (20 - FRAC);
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Works out the Lab value of one pixel.
  function automatic lab_t convert_pixel(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    longint lin [3];
    longint fc [3];
    longint acc;
    longint lv, av, bv;
    lab_t res;
    lin[0] = linear_q24[r];
    lin[1] = linear_q24[g];
    lin[2] = linear_q24[b];
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        acc += longint'(s2lab_pkg::MAT_Q20[3*i+j]) * lin[j];
      end
      fc[i] = lab_curve((acc + (64'd1 << 19)) >> 20);
    end
    lv = clip(round_q20(116 * fc[1] - (64'sd16 << 20)), 0, L_TOP);
    av = clip(round_q20(500 * (fc[0] - fc[1])), -32768, 32767);
    bv = clip(round_q20(200 * (fc[1] - fc[2])), -32768, 32767);
    res.lightness = lv[14:0];
    res.a_star    = av[15:0];
    res.b_star    = bv[15:0];
    return res;
  endfunction

  // Gap length for one item; during quiet stretches the sides never idle.
  function automatic int draw_gap();
    if (quiet_gaps) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Sends one pixel: idles for a random gap, then holds the item until accepted.
  // The expected result is queued at the edge of acceptance.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do begin
      @(posedge clk);
    end while (in_stall);
    lab_expected.push_back(convert_pixel(r, g, b));
    items_sent++;
    @(negedge clk);
  endtask

  // Directed pixels: black (lightness rounds to zero), white, the primaries and
  // secondaries, the edge of the straight gamma segment and single-bit patterns.
  task automatic test_directed();
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd10,  8'd10,  8'd10);
    send_pixel(8'd11,  8'd11,  8'd11);
    send_pixel(8'd10,  8'd11,  8'd12);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd127, 8'd127, 8'd127);
    send_pixel(8'd170, 8'd85,  8'd170);
    send_pixel(8'd85,  8'd170, 8'd85);
    send_pixel(8'd254, 8'd254, 8'd254);
  endtask

  // Random pixels with random idling, broken up by stretches of back-to-back items.
  task automatic test_random();
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k % 200 == 0) quiet_gaps = ($urandom_range(0, 2) == 0);
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end
    quiet_gaps = 1'b0;
  endtask

  // Every code on all three channels, as greys and as skewed mixtures.
  task automatic test_all_codes();
    for (int v = 0; v < 256; v++) begin
      send_pixel(8'(v), 8'(v), 8'(v));
      send_pixel(8'(v), 8'(255 - v), 8'(v ^ 8'h5a));
    end
  endtask

  // The result side stalls for a random number of cycles before each result.
  initial begin
    int hold;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      hold = draw_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(posedge clk);
      end while (!out_valid);
    end
  end

  // Compares each accepted result with the oldest expected one.
  always @(posedge clk) begin
    lab_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (lab_expected.size() == 0) begin
        $display("%0t: result with nothing expected: L=%0d a=%0d b=%0d",
                 $time, out_lightness, out_a_star, out_b_star);
        errors++;
      end else begin
        want = lab_expected.pop_front();
        if (out_lightness !== want.lightness) begin
          $display("%0t: lightness expected %0d actual %0d",
                   $time, want.lightness, out_lightness);
          errors++;
        end
        if (out_a_star !== want.a_star) begin
          $display("%0t: a_star expected %0d actual %0d",
                   $time, $signed(want.a_star), out_a_star);
          errors++;
        end
        if (out_b_star !== want.b_star) begin
          $display("%0t: b_star expected %0d actual %0d",
                   $time, $signed(want.b_star), out_b_star);
          errors++;
        end
      end
    end
  end

  // Watchdog on the cycle count.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    errors       = 0;
    items_sent   = 0;
    results_seen = 0;
    quiet_gaps   = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_red       = '0;
    in_green     = '0;
    in_blue      = '0;
    for (int v = 0; v < 256; v++) begin
      linear_q24[v] = decode_gamma(v);
    end
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_all_codes();
    test_random();
    in_valid <= 1'b0;

    // Let the pipeline drain, then keep watching for stray results.
    while (lab_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Converted %0d pixels (directed, all codes, random) and checked %0d results.",
             items_sent, results_seen);
    if (errors == 0 && lab_expected.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
